FILE: rtl/i2c_fam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_fam_pkg
// Shared types and constants of the I2C memory-device access master.
// ----------------------------------------------------------------------------
package i2c_fam_pkg;

	// request operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// control byte prefixes, device code 1010
	localparam logic [7:0] CTRL_WRITE = 8'hA0;
	localparam logic [7:0] CTRL_READ  = 8'hA1;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START    = 4'd1,
		PH_TX_LO    = 4'd2,
		PH_TX_HI    = 4'd3,
		PH_ACK_LO   = 4'd4,
		PH_ACK_HI   = 4'd5,
		PH_RS_LO    = 4'd6,
		PH_RS_HI    = 4'd7,
		PH_RS_START = 4'd8,
		PH_RX_LO    = 4'd9,
		PH_RX_HI    = 4'd10,
		PH_MACK_LO  = 4'd11,
		PH_MACK_HI  = 4'd12,
		PH_STOP_LO  = 4'd13,
		PH_STOP_HI  = 4'd14,
		PH_STOP_END = 4'd15
	} bus_phase_t;

	typedef enum logic [2:0] {
		ST_CTRL    = 3'd0,
		ST_ADDR_HI = 3'd1,
		ST_ADDR_LO = 3'd2,
		ST_DATA    = 3'd3,
		ST_RD_CTRL = 3'd4
	} byte_stage_t;

endpackage

FILE: rtl/i2c_fram_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_fram_access_master
// I2C master for random-access writes and reads of a memory device.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle whenever the output register is free or
// being drained; load and start requests produce no response, each bus tick
// produces exactly one response in the next cycle. All bus sequencing is a
// single state update per request. Write data sits in a MAX_LEN-byte RAM with
// a registered read port; the next byte to send is fetched ahead from the
// current byte position, so the RAM never holds up a tick. Loads and starts
// are only honoured while the bus is idle.
module i2c_fram_access_master #(
	parameter int MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  write_byte,
	input  logic        is_read,
	input  logic [2:0]  device_select,
	input  logic [15:0] mem_address,
	input  logic [8:0]  byte_count,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_input_mode,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        busy_res,
	output logic        done_res,
	output logic        nack_error
);
	import i2c_fam_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// state
	bus_phase_t  phase_q, phase_d;
	byte_stage_t stage_q, stage_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [CW-1:0] done_cnt_q, done_cnt_d;
	logic [CW-1:0] total_q, total_d;
	logic [15:0] addr_q, addr_d;
	logic [2:0]  chip_q, chip_d;
	logic        read_mode_q, read_mode_d;
	logic [CW-1:0] load_ptr_q, load_ptr_d;
	logic        aborted_q, aborted_d;

	// write buffer
	logic [7:0]    wbuf [MAX_LEN];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          buf_we;

	// response
	logic       res_vld;
	logic       res_scl, res_sda, res_in_mode, res_rvalid, res_busy, res_done, res_nack;
	logic [7:0] res_rbyte;
	logic       out_valid_q;
	logic       scl_q, sda_q, in_mode_q, rvalid_q, busy_q, done_q, nack_q;
	logic [7:0] rbyte_q;

	logic accept;
	logic last_byte;
	logic [7:0] shift_next_rx;
	logic [3:0] bit_cnt_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// prefetch: next data byte is the first after the address, else the following one
	assign rd_addr = (stage_q == ST_ADDR_LO) ? '0 : AW'(done_cnt_q + CW'(1));

	assign last_byte     = (done_cnt_q >= total_q);
	assign shift_next_rx = {shift_q[6:0], sda_in};
	assign bit_cnt_inc   = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d     = phase_q;
		stage_d     = stage_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		done_cnt_d  = done_cnt_q;
		total_d     = total_q;
		addr_d      = addr_q;
		chip_d      = chip_q;
		read_mode_d = read_mode_q;
		load_ptr_d  = load_ptr_q;
		aborted_d   = aborted_q;
		buf_we      = 1'b0;
		res_vld     = 1'b0;
		res_scl     = 1'b1;
		res_sda     = 1'b1;
		res_in_mode = 1'b0;
		res_rbyte   = 8'h00;
		res_rvalid  = 1'b0;
		res_busy    = 1'b1;
		res_done    = 1'b0;
		res_nack    = 1'b0;
		if (accept) begin
			case (operation)
				OP_LOAD: begin
					if (phase_q == PH_IDLE && 32'(load_ptr_q) < 32'(MAX_LEN)) begin
						buf_we     = 1'b1;
						load_ptr_d = load_ptr_q + CW'(1);
					end
				end
				OP_START: begin
					if (phase_q == PH_IDLE) begin
						read_mode_d = is_read;
						chip_d      = device_select;
						addr_d      = mem_address;
						total_d     = (32'(byte_count) > 32'(MAX_LEN)) ? CW'(MAX_LEN)
						                                             : CW'(byte_count);
						done_cnt_d  = '0;
						load_ptr_d  = '0;
						aborted_d   = 1'b0;
						shift_d     = CTRL_WRITE | {4'b0, device_select, 1'b0};
						bit_cnt_d   = '0;
						stage_d     = ST_CTRL;
						phase_d     = PH_START;
					end
				end
				OP_TICK: begin
					res_vld = 1'b1;
					case (phase_q)
						PH_START: begin
							res_sda = 1'b0;
							phase_d = PH_TX_LO;
						end
						PH_TX_LO: begin
							res_scl = 1'b0;
							res_sda = shift_q[7];
							phase_d = PH_TX_HI;
						end
						PH_TX_HI: begin
							res_sda   = shift_q[7];
							shift_d   = {shift_q[6:0], 1'b0};
							bit_cnt_d = bit_cnt_inc;
							phase_d   = (bit_cnt_inc >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
						end
						PH_ACK_LO: begin
							res_scl     = 1'b0;
							res_in_mode = 1'b1;
							phase_d     = PH_ACK_HI;
						end
						PH_ACK_HI: begin
							res_in_mode = 1'b1;
							if (sda_in) begin
								// no acknowledge: abort with stop
								aborted_d = 1'b1;
								phase_d   = PH_STOP_LO;
							end else begin
								case (stage_q)
									ST_CTRL: begin
										shift_d   = addr_q[15:8];
										bit_cnt_d = '0;
										stage_d   = ST_ADDR_HI;
										phase_d   = PH_TX_LO;
									end
									ST_ADDR_HI: begin
										shift_d   = addr_q[7:0];
										bit_cnt_d = '0;
										stage_d   = ST_ADDR_LO;
										phase_d   = PH_TX_LO;
									end
									ST_ADDR_LO: begin
										if (read_mode_q) begin
											phase_d = PH_RS_LO;
										end else if (total_q == '0) begin
											phase_d = PH_STOP_LO;
										end else begin
											done_cnt_d = '0;
											shift_d    = rd_data_q;
											bit_cnt_d  = '0;
											stage_d    = ST_DATA;
											phase_d    = PH_TX_LO;
										end
									end
									ST_DATA: begin
										done_cnt_d = done_cnt_q + CW'(1);
										if ((done_cnt_q + CW'(1)) >= total_q) begin
											phase_d = PH_STOP_LO;
										end else begin
											shift_d   = rd_data_q;
											bit_cnt_d = '0;
											phase_d   = PH_TX_LO;
										end
									end
									default: begin
										done_cnt_d = '0;
										if (total_q == '0) begin
											phase_d = PH_STOP_LO;
										end else begin
											shift_d   = '0;
											bit_cnt_d = '0;
											phase_d   = PH_RX_LO;
										end
									end
								endcase
							end
						end
						PH_RS_LO: begin
							res_scl = 1'b0;
							phase_d = PH_RS_HI;
						end
						PH_RS_HI: begin
							phase_d = PH_RS_START;
						end
						PH_RS_START: begin
							res_sda   = 1'b0;
							shift_d   = CTRL_READ | {4'b0, chip_q, 1'b0};
							bit_cnt_d = '0;
							stage_d   = ST_RD_CTRL;
							phase_d   = PH_TX_LO;
						end
						PH_RX_LO: begin
							res_scl     = 1'b0;
							res_in_mode = 1'b1;
							phase_d     = PH_RX_HI;
						end
						PH_RX_HI: begin
							res_in_mode = 1'b1;
							shift_d     = shift_next_rx;
							bit_cnt_d   = bit_cnt_inc;
							if (bit_cnt_inc >= BITS_PER_BYTE) begin
								res_rbyte  = shift_next_rx;
								res_rvalid = 1'b1;
								done_cnt_d = done_cnt_q + CW'(1);
								phase_d    = PH_MACK_LO;
							end else begin
								phase_d = PH_RX_LO;
							end
						end
						PH_MACK_LO: begin
							// nack the final byte
							res_scl = 1'b0;
							res_sda = last_byte;
							phase_d = PH_MACK_HI;
						end
						PH_MACK_HI: begin
							res_sda = last_byte;
							if (last_byte) begin
								phase_d = PH_STOP_LO;
							end else begin
								shift_d   = '0;
								bit_cnt_d = '0;
								phase_d   = PH_RX_LO;
							end
						end
						PH_STOP_LO: begin
							res_scl = 1'b0;
							res_sda = 1'b0;
							phase_d = PH_STOP_HI;
						end
						PH_STOP_HI: begin
							res_sda = 1'b0;
							phase_d = PH_STOP_END;
						end
						PH_STOP_END: begin
							res_busy  = 1'b0;
							res_done  = 1'b1;
							res_nack  = aborted_q;
							aborted_d = 1'b0;
							phase_d   = PH_IDLE;
						end
						default: begin
							res_busy = 1'b0;
							phase_d  = PH_IDLE;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			stage_q     <= ST_CTRL;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			done_cnt_q  <= '0;
			total_q     <= '0;
			addr_q      <= '0;
			chip_q      <= '0;
			read_mode_q <= 1'b0;
			load_ptr_q  <= '0;
			aborted_q   <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			stage_q     <= stage_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			done_cnt_q  <= done_cnt_d;
			total_q     <= total_d;
			addr_q      <= addr_d;
			chip_q      <= chip_d;
			read_mode_q <= read_mode_d;
			load_ptr_q  <= load_ptr_d;
			aborted_q   <= aborted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			wbuf[load_ptr_q[AW-1:0]] <= write_byte;
		end
		rd_data_q <= wbuf[rd_addr];
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			scl_q     <= res_scl;
			sda_q     <= res_sda;
			in_mode_q <= res_in_mode;
			rbyte_q   <= res_rbyte;
			rvalid_q  <= res_rvalid;
			busy_q    <= res_busy;
			done_q    <= res_done;
			nack_q    <= res_nack;
		end
	end

	assign out_valid      = out_valid_q;
	assign scl            = scl_q;
	assign sda_out        = sda_q;
	assign sda_input_mode = in_mode_q;
	assign read_byte      = rbyte_q;
	assign read_valid     = rvalid_q;
	assign busy_res       = busy_q;
	assign done_res       = done_q;
	assign nack_error     = nack_q;

endmodule
